>>> sv/vcu_pkg.sv
// Shared types and constants for the vector clock unit.
`default_nettype none

package vcu_pkg;

	// Default number of clock entries held in the clock memory.
	localparam int MAX_ENTRIES_DEF = 16;

	// Fixed field widths of the transaction payload.
	localparam int OP_W   = 2;
	localparam int IDX_W  = 4;
	localparam int VAL_W  = 32;
	localparam int ID_W   = 8;
	localparam int CLEN_W = 5;

	// Clock length after reset.
	localparam logic [CLEN_W-1:0] CLOCK_LENGTH_RESET = 5'd16;

	// Operation codes.
	typedef enum logic [OP_W-1:0] {
		OP_TICK    = 2'd0,
		OP_MERGE   = 2'd1,
		OP_COMPARE = 2'd2,
		OP_READ    = 2'd3
	} op_t;

	// Causal relation codes.
	typedef enum logic [1:0] {
		REL_FIRST_BEFORE  = 2'd0,
		REL_SECOND_BEFORE = 2'd1,
		REL_EQUAL         = 2'd2,
		REL_CONCURRENT    = 2'd3
	} rel_t;

	// One compare element handed to the order tracker.
	typedef struct packed {
		logic en;
		logic first;
		logic last;
		logic less;
		logic greater;
		logic id_less;
	} cmp_req_t;

	// Order reported on the final compare element.
	typedef struct packed {
		logic order_valid;
		logic second_first;
		rel_t relation;
	} cmp_res_t;

endpackage

`default_nettype wire

>>> sv/vcu_clock_mem.sv
// Clock entry memory with synchronous read, entry valid bits and write forwarding.
`default_nettype none

module vcu_clock_mem #(
	parameter int MAX_ENTRIES = vcu_pkg::MAX_ENTRIES_DEF,
	parameter int AW          = $clog2(MAX_ENTRIES)
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     rd_en,
	input  wire logic [AW-1:0]            rd_addr,
	output logic      [vcu_pkg::VAL_W-1:0] rd_value,
	input  wire logic                     wr_en,
	input  wire logic [AW-1:0]            wr_addr,
	input  wire logic [vcu_pkg::VAL_W-1:0] wr_data
);
	import vcu_pkg::*;

	logic [VAL_W-1:0]       mem_q [MAX_ENTRIES];
	logic [VAL_W-1:0]       rd_data_q;
	logic [MAX_ENTRIES-1:0] entry_vld_q;
	logic                   rd_vld_q;
	logic [AW-1:0]          rd_addr_q;
	logic                   last_vld_q;
	logic [AW-1:0]          last_addr_q;
	logic [VAL_W-1:0]       last_data_q;

	// Storage array: one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// Entry valid bits stand in for clearing the array at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_vld_q <= '0;
			rd_vld_q    <= 1'b0;
			rd_addr_q   <= '0;
		end else begin
			if (wr_en) begin
				entry_vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q  <= entry_vld_q[rd_addr];
				rd_addr_q <= rd_addr;
			end
		end
	end

	// The most recent write is kept so a read issued on the same edge sees it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_vld_q  <= 1'b0;
			last_addr_q <= '0;
		end else if (wr_en) begin
			last_vld_q  <= 1'b1;
			last_addr_q <= wr_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			last_data_q <= wr_data;
		end
	end

	// Read result with forwarding; unwritten entries read as zero.
	always_comb begin
		if (last_vld_q && (last_addr_q == rd_addr_q)) begin
			rd_value = last_data_q;
		end else if (rd_vld_q) begin
			rd_value = rd_data_q;
		end else begin
			rd_value = '0;
		end
	end

endmodule

`default_nettype wire

>>> sv/vcu_order_unit.sv
// Compare flag tracker that reports the causal order of two streamed vectors.
`default_nettype none

module vcu_order_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire vcu_pkg::cmp_req_t req,
	output vcu_pkg::cmp_res_t      res
);
	import vcu_pkg::*;

	logic saw_less_q;
	logic saw_greater_q;
	logic less_now;
	logic greater_now;

	// Fold the current element into the flags; a first element restarts them.
	assign less_now    = (saw_less_q && !req.first) || req.less;
	assign greater_now = (saw_greater_q && !req.first) || req.greater;

	// Flags advance on each compare transaction and clear after the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			saw_less_q    <= 1'b0;
			saw_greater_q <= 1'b0;
		end else if (req.en) begin
			if (req.last) begin
				saw_less_q    <= 1'b0;
				saw_greater_q <= 1'b0;
			end else begin
				saw_less_q    <= less_now;
				saw_greater_q <= greater_now;
			end
		end
	end

	// Order decision on the final element; ties put the smaller id first, or the second on equal ids.
	always_comb begin
		res.order_valid  = 1'b0;
		res.second_first = 1'b0;
		res.relation     = REL_FIRST_BEFORE;
		if (req.en && req.last) begin
			res.order_valid = 1'b1;
			if (less_now && !greater_now) begin
				res.relation     = REL_FIRST_BEFORE;
				res.second_first = 1'b0;
			end else if (greater_now && !less_now) begin
				res.relation     = REL_SECOND_BEFORE;
				res.second_first = 1'b1;
			end else begin
				res.relation     = less_now ? REL_CONCURRENT : REL_EQUAL;
				res.second_first = !req.id_less;
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/vector_clock_unit_top.sv
// Path: an accepted transaction passes through stage one and the output register,
// where its result is held while the output is stalled. Throughput: one
// transaction per cycle unless the output stalls, set by the read-modify-write on
// the clock memory, which forwards the most recent write to the following read.
// Reset: all clock entries read as zero, both compare flags clear, and the
// clock length returns to 16; reset is asynchronous and active low.
`default_nettype none

module vector_clock_unit_top #(
	parameter int MAX_ENTRIES = vcu_pkg::MAX_ENTRIES_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [vcu_pkg::CLEN_W-1:0] cfg_wdata,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [vcu_pkg::OP_W-1:0]   op,
	input  wire logic [vcu_pkg::IDX_W-1:0]  entry_index,
	input  wire logic [vcu_pkg::VAL_W-1:0]  value_a,
	input  wire logic [vcu_pkg::VAL_W-1:0]  value_b,
	input  wire logic [vcu_pkg::ID_W-1:0]   id_a,
	input  wire logic [vcu_pkg::ID_W-1:0]   id_b,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [vcu_pkg::VAL_W-1:0]       entry_value,
	output logic                            order_valid,
	output logic                            second_first,
	output logic [1:0]                      relation
);
	import vcu_pkg::*;

	localparam int AW    = $clog2(MAX_ENTRIES);
	localparam int LEN_W = ($clog2(MAX_ENTRIES + 1) > CLEN_W) ?
		$clog2(MAX_ENTRIES + 1) : CLEN_W;
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_ENTRIES);

	logic [CLEN_W-1:0] clock_length_q;

	logic              vld_s1;
	logic [OP_W-1:0]   op_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [VAL_W-1:0]  va_s1;
	logic [VAL_W-1:0]  vb_s1;
	logic [ID_W-1:0]   ida_s1;
	logic [ID_W-1:0]   idb_s1;

	logic              out_valid_q;
	logic [VAL_W-1:0]  entry_value_q;
	logic              order_valid_q;
	logic              second_first_q;
	logic [1:0]        relation_q;

	logic              accept;
	logic              fire;
	logic [LEN_W-1:0]  clock_len;
	logic [LEN_W-1:0]  act_len;
	logic [LEN_W-1:0]  idx_ext;
	logic              in_range;
	logic              is_last;
	logic [VAL_W-1:0]  old_value;
	logic [VAL_W-1:0]  new_value;
	logic [VAL_W-1:0]  res_value;
	logic              upd_entry;
	cmp_req_t          cmp_req;
	cmp_res_t          cmp_res;

	// Clock length register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_length_q <= CLOCK_LENGTH_RESET;
		end else if (cfg_we) begin
			clock_length_q <= cfg_wdata;
		end
	end

	// Handshake: stage one moves on when the output register is free or drained.
	assign fire     = vld_s1 && (!out_valid_q || !out_stall);
	assign in_stall = vld_s1 && !fire;
	assign accept   = in_valid && !in_stall;

	// Stage one holds the transaction while its clock entry is read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (fire) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= op;
			idx_s1 <= entry_index;
			va_s1  <= value_a;
			vb_s1  <= value_b;
			ida_s1 <= id_a;
			idb_s1 <= id_b;
		end
	end

	vcu_clock_mem #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.AW          (AW)
	) u_clock_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (AW'(entry_index)),
		.rd_value (old_value),
		.wr_en    (fire && upd_entry),
		.wr_addr  (AW'(idx_s1)),
		.wr_data  (new_value)
	);

	// Active length and range check of the addressed entry.
	assign clock_len = LEN_W'(clock_length_q);
	assign act_len   = (clock_len > MAX_LEN) ? MAX_LEN : clock_len;
	assign idx_ext   = LEN_W'(idx_s1);
	assign in_range  = idx_ext < act_len;
	assign is_last   = idx_ext == (act_len - LEN_W'(1));

	// Entry update: saturating tick, max merge or plain read; else zero.
	always_comb begin
		new_value = old_value;
		res_value = '0;
		upd_entry = 1'b0;
		if (in_range) begin
			case (op_t'(op_s1))
				OP_TICK: begin
					if (old_value != '1) begin
						new_value = old_value + VAL_W'(1);
					end
					res_value = new_value;
					upd_entry = 1'b1;
				end
				OP_MERGE: begin
					if (old_value < va_s1) begin
						new_value = va_s1;
					end
					res_value = new_value;
					upd_entry = 1'b1;
				end
				OP_READ: begin
					res_value = old_value;
				end
				default: begin
					res_value = '0;
				end
			endcase
		end
	end

	// Compare element for the order tracker.
	always_comb begin
		cmp_req.en      = fire && in_range && (op_t'(op_s1) == OP_COMPARE);
		cmp_req.first   = idx_s1 == '0;
		cmp_req.last    = is_last;
		cmp_req.less    = va_s1 < vb_s1;
		cmp_req.greater = va_s1 > vb_s1;
		cmp_req.id_less = ida_s1 < idb_s1;
	end

	vcu_order_unit u_order_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cmp_req),
		.res    (cmp_res)
	);

	// Output register holds one result until the transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			entry_value_q  <= res_value;
			order_valid_q  <= cmp_res.order_valid;
			second_first_q <= cmp_res.second_first;
			relation_q     <= cmp_res.relation;
		end
	end

	assign out_valid    = out_valid_q;
	assign entry_value  = entry_value_q;
	assign order_valid  = order_valid_q;
	assign second_first = second_first_q;
	assign relation     = relation_q;

endmodule

`default_nettype wire

>>> bench/vector_clock_checker.sv
// Checker that predicts every vector clock unit result and compares it with the block's output.
module vector_clock_checker #(
	parameter int MAX_ENTRIES = vcu_pkg::MAX_ENTRIES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [vcu_pkg::CLEN_W-1:0] cfg_wdata,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [vcu_pkg::OP_W-1:0]   op,
	input  logic [vcu_pkg::IDX_W-1:0]  entry_index,
	input  logic [vcu_pkg::VAL_W-1:0]  value_a,
	input  logic [vcu_pkg::VAL_W-1:0]  value_b,
	input  logic [vcu_pkg::ID_W-1:0]   id_a,
	input  logic [vcu_pkg::ID_W-1:0]   id_b,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic [vcu_pkg::VAL_W-1:0]  entry_value,
	input  logic                       order_valid,
	input  logic                       second_first,
	input  logic [1:0]                 relation,
	output int                         fail_count,
	output int                         pending,
	output int                         orders_reported
);
	timeunit 1ns;
	timeprecision 1ps;
	import vcu_pkg::*;

	// One result transaction as the block should deliver it.
	typedef struct packed {
		logic [VAL_W-1:0] entry_value;
		logic             order_valid;
		logic             second_first;
		rel_t             relation;
	} clock_result_t;

	// Shadow copy of the block's state and its one register.
	logic [VAL_W-1:0]  clock_entries [MAX_ENTRIES];
	logic              saw_less;
	logic              saw_greater;
	logic [CLEN_W-1:0] clock_length;
	clock_result_t     expected_results [$];

	// Apply one input transaction to the shadow state and return its result.
	function automatic clock_result_t predict_clock_op(op_t code, logic [IDX_W-1:0] idx,
			logic [VAL_W-1:0] va, logic [VAL_W-1:0] vb,
			logic [ID_W-1:0] ida, logic [ID_W-1:0] idb);
		clock_result_t res;
		int            len;
		res = '0;
		len = (clock_length > MAX_ENTRIES) ? MAX_ENTRIES : int'(clock_length);
		if (idx < len) begin
			case (code)
				OP_TICK: begin
					if (clock_entries[idx] != '1)
						clock_entries[idx] = clock_entries[idx] + VAL_W'(1);
					res.entry_value = clock_entries[idx];
				end
				OP_MERGE: begin
					if (clock_entries[idx] < va)
						clock_entries[idx] = va;
					res.entry_value = clock_entries[idx];
				end
				OP_COMPARE: begin
					// An element at index zero starts a new comparison.
					if (idx == 0) begin
						saw_less = 1'b0;
						saw_greater = 1'b0;
					end
					if (va < vb)
						saw_less = 1'b1;
					if (va > vb)
						saw_greater = 1'b1;
					// The last element in use reports the order and clears the flags.
					if (idx == len - 1) begin
						res.order_valid = 1'b1;
						if (saw_less && !saw_greater) begin
							res.relation = REL_FIRST_BEFORE;
							res.second_first = 1'b0;
						end else if (saw_greater && !saw_less) begin
							res.relation = REL_SECOND_BEFORE;
							res.second_first = 1'b1;
						end else begin
							res.relation = saw_less ? REL_CONCURRENT : REL_EQUAL;
							res.second_first = (ida < idb) ? 1'b0 : 1'b1;
						end
						saw_less = 1'b0;
						saw_greater = 1'b0;
					end
				end
				default: begin
					res.entry_value = clock_entries[idx];
				end
			endcase
		end
		return res;
	endfunction

	// Report and count one field that differs from its expectation.
	function automatic void check_field(string name, logic [VAL_W-1:0] want,
			logic [VAL_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	// Sample both channels and the register port at every rising edge.
	always @(posedge clk) begin
		clock_result_t want;
		if (!arst_n) begin
			foreach (clock_entries[i])
				clock_entries[i] = '0;
			saw_less = 1'b0;
			saw_greater = 1'b0;
			clock_length = CLOCK_LENGTH_RESET;
			expected_results.delete();
		end else begin
			// A result transaction is matched against the oldest expectation.
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result with none expected, actual entry_value 0x%0h", $time,
						entry_value);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("entry_value", want.entry_value, entry_value);
					check_field("order_valid", VAL_W'(want.order_valid), VAL_W'(order_valid));
					check_field("second_first", VAL_W'(want.second_first),
						VAL_W'(second_first));
					check_field("relation", VAL_W'(want.relation), VAL_W'(relation));
				end
			end
			if (cfg_we)
				clock_length = cfg_wdata;
			if (in_valid && !in_stall) begin
				want = predict_clock_op(op_t'(op), entry_index, value_a, value_b, id_a, id_b);
				if (want.order_valid)
					orders_reported++;
				expected_results.push_back(want);
			end
		end
		pending = expected_results.size();
	end

endmodule

>>> bench/testbench.sv
// Top of the vector clock unit bench: clock, reset, stimulus, receiver stalls and verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import vcu_pkg::*;

	// Shapes of a streamed compare vector.
	typedef enum int {
		STREAM_EQUAL,
		STREAM_LESS,
		STREAM_GREATER,
		STREAM_MIXED,
		STREAM_RANDOM
	} stream_kind_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [CLEN_W-1:0] cfg_wdata = CLOCK_LENGTH_RESET;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [OP_W-1:0]   op = OP_TICK;
	logic [IDX_W-1:0]  entry_index = '0;
	logic [VAL_W-1:0]  value_a = '0;
	logic [VAL_W-1:0]  value_b = '0;
	logic [ID_W-1:0]   id_a = '0;
	logic [ID_W-1:0]   id_b = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [VAL_W-1:0]  entry_value;
	logic              order_valid;
	logic              second_first;
	logic [1:0]        relation;

	int fail_count;
	int pending;
	int orders_reported;
	int items_sent = 0;
	int active_len = MAX_ENTRIES_DEF;
	int lengths_used = 0;
	int no_gap_left = 0;
	int next_hold_at = 300;

	vector_clock_unit_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.entry_index  (entry_index),
		.value_a      (value_a),
		.value_b      (value_b),
		.id_a         (id_a),
		.id_b         (id_b),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.entry_value  (entry_value),
		.order_valid  (order_valid),
		.second_first (second_first),
		.relation     (relation)
	);

	vector_clock_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.op              (op),
		.entry_index     (entry_index),
		.value_a         (value_a),
		.value_b         (value_b),
		.id_a            (id_a),
		.id_b            (id_b),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.entry_value     (entry_value),
		.order_valid     (order_valid),
		.second_first    (second_first),
		.relation        (relation),
		.fail_count      (fail_count),
		.pending         (pending),
		.orders_reported (orders_reported)
	);

	// 100 MHz clock.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Values weighted toward the edges of the 32-bit range and small counts.
	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return 32'hFFFF_FFFE;
			3, 4: return $urandom_range(0, 20);
			5: return 32'h8000_0000 | $urandom_range(0, 3);
			default: return $urandom;
		endcase
	endfunction

	// Mostly an index in use, sometimes any index at all.
	function automatic logic [IDX_W-1:0] pick_index();
		if (active_len > 0 && $urandom_range(0, 9) != 0)
			return IDX_W'($urandom_range(0, active_len - 1));
		return IDX_W'($urandom_range(0, 15));
	endfunction

	// Sender gap: mostly none or short, a few long, with occasional gap-free bursts.
	function automatic int pick_gap();
		int r;
		if (no_gap_left > 0) begin
			no_gap_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			no_gap_left = 30;
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 25);
	endfunction

	// Offer one input transaction, wait for acceptance, then idle for a random gap.
	task automatic send_item(op_t code, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] va,
			logic [VAL_W-1:0] vb, logic [ID_W-1:0] ida, logic [ID_W-1:0] idb);
		int gap;
		in_valid <= 1'b1;
		op <= code;
		entry_index <= idx;
		value_a <= va;
		value_b <= vb;
		id_a <= ida;
		id_b <= idb;
		do
			@(posedge clk);
		while (in_stall);
		items_sent++;
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Drain the block, then write a new clock length.
	task automatic set_clock_length(logic [CLEN_W-1:0] length);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= length;
		@(negedge clk);
		cfg_we <= 1'b0;
		active_len = (length > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : int'(length);
		lengths_used++;
	endtask

	// Stream one compare vector over the entries in use, now and then cut short.
	task automatic send_compare_stream();
		stream_kind_t     kind;
		int               stop;
		int               i;
		logic [VAL_W-1:0] x;
		logic [VAL_W-1:0] y;
		logic [VAL_W-1:0] lo;
		logic [VAL_W-1:0] hi;
		logic [VAL_W-1:0] a;
		logic [VAL_W-1:0] b;
		logic [ID_W-1:0]  ida;
		logic [ID_W-1:0]  idb;
		kind = stream_kind_t'($urandom_range(0, 4));
		ida = ID_W'($urandom_range(0, 255));
		idb = ($urandom_range(0, 3) == 0) ? ida : ID_W'($urandom_range(0, 255));
		stop = active_len;
		if (active_len > 1 && $urandom_range(0, 9) == 0)
			stop = $urandom_range(1, active_len - 1);
		for (i = 0; i < stop; i++) begin
			x = pick_value();
			y = pick_value();
			if (x == y)
				y = x ^ 32'h1;
			lo = (x < y) ? x : y;
			hi = (x < y) ? y : x;
			a = x;
			b = x;
			case (kind)
				STREAM_LESS: if ($urandom_range(0, 1)) begin a = lo; b = hi; end
				STREAM_GREATER: if ($urandom_range(0, 1)) begin a = hi; b = lo; end
				STREAM_MIXED: begin
					case ($urandom_range(0, 2))
						1: begin a = lo; b = hi; end
						2: begin a = hi; b = lo; end
						default: ;
					endcase
				end
				STREAM_RANDOM: begin
					a = x;
					b = y;
				end
				default: ;
			endcase
			send_item(OP_COMPARE, IDX_W'(i), a, b, ida, idb);
		end
	endtask

	// Random traffic: mostly whole compare vectors and entry updates, some noise.
	task automatic run_random_phase(int count);
		int target;
		int r;
		target = items_sent + count;
		while (items_sent < target) begin
			r = $urandom_range(0, 99);
			if (r < 35 && active_len > 0)
				send_compare_stream();
			else if (r < 50)
				send_item(OP_TICK, pick_index(), $urandom, $urandom, ID_W'($urandom),
					ID_W'($urandom));
			else if (r < 65)
				send_item(OP_MERGE, pick_index(), pick_value(), $urandom, ID_W'($urandom),
					ID_W'($urandom));
			else if (r < 80)
				send_item(OP_READ, pick_index(), $urandom, $urandom, ID_W'($urandom),
					ID_W'($urandom));
			else
				send_item(op_t'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 15)),
					$urandom, $urandom, ID_W'($urandom), ID_W'($urandom));
		end
	endtask

	// Receiver: random stalls, stall-free stretches and long hold-offs.
	initial begin
		int n;
		int r;
		@(negedge clk);
		forever begin
			if (items_sent >= next_hold_at) begin
				// Hold off long enough that the block fills and stalls its input.
				out_stall <= 1'b1;
				n = 120;
				next_hold_at += 600;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 20) begin
					out_stall <= 1'b0;
					n = $urandom_range(20, 60);
				end else if (r < 50) begin
					out_stall <= 1'b1;
					n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) :
						$urandom_range(8, 30);
				end else begin
					out_stall <= 1'b0;
					n = $urandom_range(1, 3);
				end
			end
			repeat (n) @(negedge clk);
		end
	end

	// Stimulus and verdict.
	initial begin
		logic [CLEN_W-1:0] length_plan [8];
		length_plan = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd2, 5'd2, 5'd16, 5'd3};
		length_plan[4] = CLEN_W'($urandom_range(2, 15));
		length_plan[5] = CLEN_W'($urandom_range(2, 15));

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Entry updates at the reset length: counting, saturation and keeping the maximum.
		send_item(OP_TICK, 4'd0, '0, '0, 8'd0, 8'd0);
		send_item(OP_TICK, 4'd0, '1, '1, 8'd255, 8'd255);
		send_item(OP_READ, 4'd0, '0, '0, 8'd0, 8'd0);
		send_item(OP_MERGE, 4'd1, '1, '0, 8'd0, 8'd0);
		send_item(OP_TICK, 4'd1, '0, '0, 8'd0, 8'd0);
		send_item(OP_READ, 4'd1, '0, '0, 8'd0, 8'd0);
		send_item(OP_MERGE, 4'd15, 32'd5, '1, 8'd0, 8'd0);
		send_item(OP_MERGE, 4'd15, 32'd3, '1, 8'd0, 8'd0);
		send_item(OP_READ, 4'd15, '0, '0, 8'd0, 8'd0);

		// Two-entry vectors: each relation, both tie breaks, a restart, indices out of range.
		set_clock_length(5'd2);
		send_item(OP_COMPARE, 4'd0, '0, '1, 8'd1, 8'd2);
		send_item(OP_COMPARE, 4'd1, 32'd7, 32'd7, 8'd1, 8'd2);
		send_item(OP_COMPARE, 4'd0, '1, '0, 8'd1, 8'd2);
		send_item(OP_COMPARE, 4'd1, 32'd3, 32'd3, 8'd1, 8'd2);
		send_item(OP_COMPARE, 4'd0, 32'd9, 32'd9, 8'd0, 8'd255);
		send_item(OP_COMPARE, 4'd1, '0, '0, 8'd0, 8'd255);
		send_item(OP_COMPARE, 4'd0, '1, '1, 8'd255, 8'd0);
		send_item(OP_COMPARE, 4'd1, '1, '1, 8'd255, 8'd0);
		send_item(OP_COMPARE, 4'd0, 32'd1, 32'd2, 8'd10, 8'd10);
		send_item(OP_COMPARE, 4'd1, 32'd2, 32'd1, 8'd10, 8'd10);
		send_item(OP_COMPARE, 4'd0, 32'd1, 32'd2, 8'd4, 8'd5);
		send_item(OP_COMPARE, 4'd0, 32'd4, 32'd4, 8'd4, 8'd5);
		send_item(OP_COMPARE, 4'd1, 32'd8, 32'd6, 8'd4, 8'd5);
		send_item(OP_TICK, 4'd2, '0, '0, 8'd0, 8'd0);
		send_item(OP_MERGE, 4'd15, '1, '1, 8'd0, 8'd0);
		send_item(OP_READ, 4'd1, '0, '0, 8'd0, 8'd0);

		// Random phases over several clock lengths, including zero and beyond the maximum.
		foreach (length_plan[p]) begin
			set_clock_length(length_plan[p]);
			run_random_phase((length_plan[p] == 0) ? 40 : 190);
		end

		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		$display("Covered %0d transactions under %0d clock length settings, %0d of them",
			items_sent, lengths_used, orders_reported);
		$display("final compare elements that reported an order.");
		if (fail_count == 0)
			$display("vector_clock_unit_top regression: pass");
		else
			$display("vector_clock_unit_top regression: fail");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#5_000_000;
		$display("vector_clock_unit_top regression: fail");
		$finish;
	end

endmodule

>>> sim.f
sv/vcu_pkg.sv
sv/vcu_clock_mem.sv
sv/vcu_order_unit.sv
sv/vector_clock_unit_top.sv
bench/vector_clock_checker.sv
bench/testbench.sv
